### hw/rtl/asp_pkg.sv
// Shared types and constants of the atlas shelf packer.
`default_nettype none

package asp_pkg;

   localparam int unsigned MAX_PAGES = 256;
   localparam int unsigned PAGE_W = 8;
   localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(MAX_PAGES - 1);

   localparam int unsigned EDGE_W = 15;
   localparam int unsigned PAD_W = 8;
   localparam int unsigned RECT_W = 14;
   localparam int unsigned POS_W = 14;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 15;

   localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(512);
   localparam logic [PAD_W-1:0] PAD_RESET = PAD_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_EDGE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDING = 1'b1;

   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CURRENT  = 2'd0,
      STATUS_FRESH    = 2'd1,
      STATUS_TOO_BIG  = 2'd2,
      STATUS_NO_PAGES = 2'd3
   } status_type;

   typedef struct packed {
      logic [EDGE_W-1:0] atlas_edge;
      logic [PAD_W-1:0]  padding;
   } cfg_type;

   // Classified item: padded size, padded size plus the trailing gap, and
   // whether it fits an empty page at all.
   typedef struct packed {
      logic              too_big;
      logic [EDGE_W-1:0] pw;
      logic [EDGE_W-1:0] ph;
      logic [EDGE_W-1:0] pw_gap;
      logic [EDGE_W-1:0] ph_gap;
   } cmd_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page_index;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      status_type        status;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/asp_front.sv
// Front end: configuration registers, input register and size classification.
`default_nettype none

module asp_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [asp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [asp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_push,
   output      logic                           req_full,
   input  wire logic [asp_pkg::RECT_W-1:0]     req_rect_width,
   input  wire logic [asp_pkg::RECT_W-1:0]     req_rect_height,
   output      asp_pkg::cfg_type               cfg,
   output      logic                           cmd_push,
   output      asp_pkg::cmd_type               cmd_data,
   input  wire logic                           cmd_full
);
   import asp_pkg::*;

   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic              valid_ff, valid_in;
   cmd_type           cmd_ff, cmd_in;
   logic              accept;
   logic [EDGE_W-1:0] pad_ext;

   always_comb begin
      edge_in = edge_ff;
      pad_in = pad_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATLAS_EDGE: edge_in = csr_wdata[EDGE_W-1:0];
            CSR_PADDING:    pad_in = csr_wdata[PAD_W-1:0];
            default:        ;
         endcase
      end
   end

   assign cfg.atlas_edge = edge_ff;
   assign cfg.padding = pad_ff;

   assign pad_ext = {{(EDGE_W-PAD_W){1'b0}}, pad_ff};

   always_comb begin
      cmd_in.pw = {1'b0, req_rect_width} + pad_ext;
      cmd_in.ph = {1'b0, req_rect_height} + pad_ext;
      cmd_in.pw_gap = cmd_in.pw + pad_ext;
      cmd_in.ph_gap = cmd_in.ph + pad_ext;
      cmd_in.too_big = !((cmd_in.pw_gap < edge_ff) && (cmd_in.ph_gap < edge_ff));
   end

   assign req_full = valid_ff && cmd_full;
   assign accept = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;
   assign cmd_data = cmd_ff;
   assign valid_in = accept || (valid_ff && cmd_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= EDGE_RESET;
         pad_ff <= PAD_RESET;
         valid_ff <= 1'b0;
      end else begin
         edge_ff <= edge_in;
         pad_ff <= pad_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/asp_queue.sv
// Short queue of classified items between the front and the back end.
`default_nettype none

module asp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire asp_pkg::cmd_type push_data,
   output      logic             full,
   input  wire logic             pop,
   output      asp_pkg::cmd_type pop_data,
   output      logic             empty
);
   import asp_pkg::*;

   cmd_type                 mem [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]    wptr_ff, wptr_in;
   logic [CMD_PTR_W-1:0]    rptr_ff, rptr_in;
   logic [CMD_CNT_W-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign full = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/asp_back.sv
// Back end: shelf placement state, decision logic and the result queue.
`default_nettype none

module asp_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire asp_pkg::cfg_type             cfg,
   input  wire logic                         cmd_empty,
   input  wire asp_pkg::cmd_type             cmd_data,
   output      logic                         cmd_pop,
   output      logic                         rsp_empty,
   input  wire logic                         rsp_pop,
   output      logic [asp_pkg::PAGE_W-1:0]   rsp_page_index,
   output      logic [asp_pkg::POS_W-1:0]    rsp_pos_x,
   output      logic [asp_pkg::POS_W-1:0]    rsp_pos_y,
   output      logic [asp_pkg::STATUS_W-1:0] rsp_status
);
   import asp_pkg::*;

   logic [PAGE_W-1:0] page_ff, page_in;
   logic [EDGE_W-1:0] rows_ff, rows_in;
   logic [EDGE_W-1:0] rowh_ff, rowh_in;
   logic [EDGE_W-1:0] col_ff, col_in;

   rsp_type     out_mem [2];
   logic        out_wptr_ff, out_wptr_in;
   logic        out_rptr_ff, out_rptr_in;
   logic [1:0]  out_cnt_ff, out_cnt_in;
   logic        out_pop, out_ready, step;

   logic [EDGE_W-1:0] pad_ext;
   logic [EDGE_W:0]   next_top;
   logic              fit_cur, fit_row;
   logic [EDGE_W-1:0] base_col, base_rows, base_rowh;
   logic              placed;
   rsp_type           result;

   assign pad_ext = {{(EDGE_W-PAD_W){1'b0}}, cfg.padding};
   assign next_top = {1'b0, rows_ff} + {1'b0, rowh_ff};

   // Strict compares: the trailing gap must also stay inside the page.
   assign fit_cur = (({1'b0, rows_ff} + {1'b0, cmd_data.ph_gap}) < {1'b0, cfg.atlas_edge})
                 && (({1'b0, col_ff} + {1'b0, cmd_data.pw_gap}) < {1'b0, cfg.atlas_edge});
   assign fit_row = (({1'b0, next_top} + {2'b0, cmd_data.ph_gap})
                     < {2'b0, cfg.atlas_edge});

   assign out_pop = rsp_pop && !rsp_empty;
   assign out_ready = (out_cnt_ff != 2'd2) || out_pop;
   assign step = !cmd_empty && out_ready;
   assign cmd_pop = step;

   always_comb begin
      page_in = page_ff;
      base_col = col_ff;
      base_rows = rows_ff;
      base_rowh = rowh_ff;
      placed = 1'b1;
      result.page_index = page_ff;
      result.pos_x = '0;
      result.pos_y = '0;
      result.status = STATUS_CURRENT;
      priority if (cmd_data.too_big) begin
         placed = 1'b0;
         result.status = STATUS_TOO_BIG;
      end else if (fit_cur) begin
         result.status = STATUS_CURRENT;
      end else if (fit_row) begin
         base_rows = next_top[EDGE_W-1:0];
         base_rowh = '0;
         base_col = '0;
      end else if (page_ff == PAGE_LAST) begin
         placed = 1'b0;
         result.status = STATUS_NO_PAGES;
      end else begin
         page_in = page_ff + 1'b1;
         base_rows = '0;
         base_rowh = '0;
         base_col = '0;
         result.page_index = page_in;
         result.status = STATUS_FRESH;
      end
      rows_in = rows_ff;
      rowh_in = rowh_ff;
      col_in = col_ff;
      if (placed) begin
         result.pos_x = POS_W'(base_col + pad_ext);
         result.pos_y = POS_W'(base_rows + pad_ext);
         rows_in = base_rows;
         rowh_in = (cmd_data.ph > base_rowh) ? cmd_data.ph : base_rowh;
         col_in = base_col + cmd_data.pw;
      end
   end

   always_comb begin
      out_wptr_in = out_wptr_ff;
      out_rptr_in = out_rptr_ff;
      out_cnt_in = out_cnt_ff;
      if (step) begin
         out_wptr_in = !out_wptr_ff;
      end
      if (out_pop) begin
         out_rptr_in = !out_rptr_ff;
      end
      if (step && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !step) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         rows_ff <= '0;
         rowh_ff <= '0;
         col_ff <= '0;
         out_wptr_ff <= 1'b0;
         out_rptr_ff <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         if (step) begin
            page_ff <= page_in;
            rows_ff <= rows_in;
            rowh_ff <= rowh_in;
            col_ff <= col_in;
         end
         out_wptr_ff <= out_wptr_in;
         out_rptr_ff <= out_rptr_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_mem[out_wptr_ff] <= result;
      end
   end

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_page_index = out_mem[out_rptr_ff].page_index;
   assign rsp_pos_x = out_mem[out_rptr_ff].pos_x;
   assign rsp_pos_y = out_mem[out_rptr_ff].pos_y;
   assign rsp_status = out_mem[out_rptr_ff].status;

   a_page_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (page_ff == $past(page_ff)) || (page_ff == $past(page_ff) + 1'b1))
      else $error("page index moved by more than one");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      step && cmd_data.too_big |=> $stable(page_ff) && $stable(rows_ff)
         && $stable(rowh_ff) && $stable(col_ff))
      else $error("oversized item changed the shelf state");

   a_out_bounded: assert property (@(posedge clock) disable iff (reset)
      !reset |-> (out_cnt_ff <= 2'd2) && !(step && (out_cnt_ff == 2'd2) && !out_pop))
      else $error("result queue overflow");

endmodule

`default_nettype wire

### hw/rtl/atlas_shelf_packer_top.sv
// Top level of the atlas shelf packer: front end, item queue and back end.
//
//  Channel   Handshake             Payload
//  req_      push / full           rect_width, rect_height
//  rsp_      empty / pop           page_index, pos_x, pos_y, status
//  csr_      we (no wait)          index, wdata (atlas_edge, padding)
//
// One item per clock is sustained while results are popped; the back end updates
// the shelf state once per cycle in which it takes an item. An item's result is
// on the result ports once the item has passed the input register and the item
// queue and its result is written into the result queue, and it can be popped at
// the next edge. Synchronous reset clears the page and shelf state and loads
// atlas_edge = 512 and padding = 1. A stalled result side fills the two-entry
// result queue, then the four-entry item queue and the input register, and only then raises full.
`default_nettype none

module atlas_shelf_packer_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [asp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [asp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_push,
   output      logic                           req_full,
   input  wire logic [asp_pkg::RECT_W-1:0]     req_rect_width,
   input  wire logic [asp_pkg::RECT_W-1:0]     req_rect_height,
   output      logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   output      logic [asp_pkg::PAGE_W-1:0]     rsp_page_index,
   output      logic [asp_pkg::POS_W-1:0]      rsp_pos_x,
   output      logic [asp_pkg::POS_W-1:0]      rsp_pos_y,
   output      logic [asp_pkg::STATUS_W-1:0]   rsp_status
);
   import asp_pkg::*;

   cfg_type cfg;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_in, q_out;

   asp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .cfg             (cfg),
      .cmd_push        (q_push),
      .cmd_data        (q_in),
      .cmd_full        (q_full)
   );

   asp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   asp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd_empty      (q_empty),
      .cmd_data       (q_out),
      .cmd_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_page_index (rsp_page_index),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
